[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is low.
`define PMST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, quiet while reset is low.
`define PMST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/pmst_pkg.sv]
`default_nettype none

package pmst_pkg;

  localparam int VERT_BITS = 5;
  localparam int WGT_BITS  = 16;
  localparam int CNT_BITS  = 6;

  typedef logic [VERT_BITS-1:0] vert_t;
  typedef logic [WGT_BITS-1:0]  wgt_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  localparam cnt_t VCOUNT_RESET = 6'd32;

endpackage

`default_nettype wire

[rtl/pmst_edge_if.sv]
`default_nettype none

interface pmst_edge_if;
  import pmst_pkg::*;

  logic  valid;
  logic  ready;
  vert_t vert_a;
  vert_t vert_b;
  wgt_t  edge_weight;
  logic  last_edge;

  modport source (output valid, output vert_a, output vert_b, output edge_weight,
                  output last_edge, input ready);
  modport sink (input valid, input vert_a, input vert_b, input edge_weight,
                input last_edge, output ready);
endinterface

`default_nettype wire

[rtl/pmst_tree_if.sv]
`default_nettype none

interface pmst_tree_if;
  import pmst_pkg::*;

  logic  valid;
  logic  ready;
  vert_t tree_vertex;
  vert_t tree_parent;
  wgt_t  tree_weight;
  logic  reachable;
  logic  last_result;

  modport source (output valid, output tree_vertex, output tree_parent,
                  output tree_weight, output reachable, output last_result, input ready);
  modport sink (input valid, input tree_vertex, input tree_parent,
                input tree_weight, input reachable, input last_result, output ready);
endinterface

`default_nettype wire

[rtl/pmst_cfg_if.sv]
`default_nettype none

interface pmst_cfg_if;
  import pmst_pkg::*;

  logic valid;
  logic ready;
  cnt_t vertex_count;

  modport source (output valid, output vertex_count, input ready);
  modport sink (input valid, input vertex_count, output ready);
endinterface

`default_nettype wire

[rtl/prim_mst_dense.sv]
// Channel   Dir  Beat payload
// in_edge   in   vert_a, vert_b, edge_weight, last_edge
// out_tree  out  tree_vertex, tree_parent, tree_weight, reachable, last_result
// cfg_wr    in   vertex_count (always ready)
//
// Edge beats are taken one per cycle in S_LOAD; each is stored once in the upper
// triangle. A beat with last_edge runs Prim: N passes over one shared compare unit
// and the single read port of the adjacency RAM. Results for vertices 1..N-1 then
// leave one beat at a time through S_ORD, S_OLD and S_OWAIT, which waits out any
// out_tree stall. After reset and after every run the adjacency RAM is zeroed:
// all 2**(2*clog2(MAX_VERTICES)) words (1024 by default); in_edge is not ready then.
`default_nettype none

`include "assert_macros.svh"

module prim_mst_dense #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  pmst_edge_if.sink    in_edge,
  pmst_tree_if.source  out_tree,
  pmst_cfg_if.sink     cfg_wr
);
  import pmst_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int KW = WEIGHT_BITS + 1;
  localparam int AW = 2 * VW;

  localparam logic [KW-1:0] KEY_INF = KW'(1) << WEIGHT_BITS;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_ORD   = 3'd4;
  localparam logic [2:0] S_OLD   = 3'd5;
  localparam logic [2:0] S_OWAIT = 3'd6;

  logic [2:0]              state_r, state_nxt;
  cnt_t                    vcount_r;
  logic [CW-1:0]           n_r, n_nxt, n_cfg;
  logic [CW-1:0]           iss_r, iss_nxt;
  logic                    s1_v_r, s1_v_nxt;
  logic [VW-1:0]           s1_idx_r, s1_idx_nxt;
  logic                    first_r, first_nxt;
  logic [VW-1:0]           pick_r, pick_nxt;
  logic [CW-1:0]           picks_r, picks_nxt;
  logic                    conn_ok_r, conn_ok_nxt;
  logic [KW-1:0]           best_r, best_nxt;
  logic [VW-1:0]           bidx_r, bidx_nxt;
  logic                    found_r, found_nxt;
  logic [VW-1:0]           ffree_r, ffree_nxt;
  logic                    ffree_ok_r, ffree_ok_nxt;
  logic [MAX_VERTICES-1:0] in_tree_r, in_tree_nxt;
  logic [MAX_VERTICES-1:0] conn_r, conn_nxt;
  logic [CW-1:0]           ov_r, ov_nxt;
  logic [AW-1:0]           clr_r, clr_nxt;

  logic                    oval_r, oval_nxt;
  vert_t                   overt_r, overt_nxt;
  vert_t                   opar_r, opar_nxt;
  wgt_t                    owgt_r, owgt_nxt;
  logic                    oreach_r, oreach_nxt;
  logic                    olast_r, olast_nxt;

  // adjacency RAM, upper triangle addressed {low, high}
  logic [WEIGHT_BITS-1:0]  adj_mem [2**AW];
  logic [WEIGHT_BITS-1:0]  adj_q_r;
  logic                    adj_we;
  logic [AW-1:0]           adj_waddr, adj_raddr;
  logic [WEIGHT_BITS-1:0]  adj_wdata;

  logic [KW-1:0]           key_mem [MAX_VERTICES];
  logic [VW-1:0]           par_mem [MAX_VERTICES];
  logic [KW-1:0]           key_q_r;
  logic [VW-1:0]           par_q_r;
  logic                    kp_we;
  logic [VW-1:0]           kp_waddr, kp_raddr;
  logic [KW-1:0]           key_wdata;
  logic [VW-1:0]           par_wdata;

  logic                    in_fire, out_fire, in_range;
  logic [VW-1:0]           ea, eb, elo, ehi;
  logic [VW-1:0]           scan_v, slo, shi;
  logic [WEIGHT_BITS-1:0]  wgt_in;
  logic                    relax, it_cur;
  logic [KW-1:0]           knew;
  logic [VW-1:0]           pick_sel;
  logic                    conn_now;
  logic [CW-1:0]           picks_inc;

  assign in_edge.ready = (state_r == S_LOAD);
  assign cfg_wr.ready  = 1'b1;
  assign in_fire       = in_edge.valid & in_edge.ready;
  assign out_fire      = out_tree.valid & out_tree.ready;

  assign out_tree.valid       = oval_r;
  assign out_tree.tree_vertex = overt_r;
  assign out_tree.tree_parent = opar_r;
  assign out_tree.tree_weight = owgt_r;
  assign out_tree.reachable   = oreach_r;
  assign out_tree.last_result = olast_r;

  // clamp the vertex count to 1..MAX_VERTICES
  always_comb begin
    if (vcount_r == '0) begin
      n_cfg = CW'(1);
    end else if (32'(vcount_r) > MAX_VERTICES) begin
      n_cfg = CW'(MAX_VERTICES);
    end else begin
      n_cfg = CW'(vcount_r);
    end
  end

  // edge load address
  assign ea       = VW'(in_edge.vert_a);
  assign eb       = VW'(in_edge.vert_b);
  assign elo      = (ea < eb) ? ea : eb;
  assign ehi      = (ea < eb) ? eb : ea;
  assign in_range = (32'(in_edge.vert_a) < MAX_VERTICES) &&
                    (32'(in_edge.vert_b) < MAX_VERTICES);
  assign wgt_in   = WEIGHT_BITS'(in_edge.edge_weight);

  // scan read address: row of the current pick, column of the issued vertex
  assign scan_v    = iss_r[VW-1:0];
  assign slo       = (pick_r < scan_v) ? pick_r : scan_v;
  assign shi       = (pick_r < scan_v) ? scan_v : pick_r;
  assign adj_raddr = {slo, shi};

  always_comb begin
    if (state_r == S_CLEAR) begin
      adj_we    = 1'b1;
      adj_waddr = clr_r;
      adj_wdata = '0;
    end else begin
      adj_we    = in_fire & in_range;
      adj_waddr = {elo, ehi};
      adj_wdata = wgt_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_q_r <= adj_mem[adj_raddr];
  end

  // relax and compare for the vertex whose data just came back
  assign it_cur = in_tree_r[s1_idx_r];
  assign relax  = (adj_q_r != '0) && !it_cur && (KW'(adj_q_r) < key_q_r);

  always_comb begin
    if (first_r) begin
      knew = (s1_idx_r == '0) ? '0 : KEY_INF;
    end else if (relax) begin
      knew = KW'(adj_q_r);
    end else begin
      knew = key_q_r;
    end
  end

  assign pick_sel  = found_r ? bidx_r : ffree_r;
  assign conn_now  = conn_ok_r & found_r;
  assign picks_inc = picks_r + CW'(1);

  always_comb begin
    if (state_r == S_PICK) begin
      kp_we     = !found_r;
      kp_waddr  = ffree_r;
      key_wdata = '0;
      par_wdata = '0;
    end else begin
      kp_we     = s1_v_r & (first_r | relax);
      kp_waddr  = s1_idx_r;
      key_wdata = knew;
      par_wdata = first_r ? '0 : pick_r;
    end
  end

  assign kp_raddr = (state_r == S_SCAN) ? scan_v : ov_r[VW-1:0];

  always_ff @(posedge clk) begin
    if (kp_we) begin
      key_mem[kp_waddr] <= key_wdata;
      par_mem[kp_waddr] <= par_wdata;
    end
    key_q_r <= key_mem[kp_raddr];
    par_q_r <= par_mem[kp_raddr];
  end

  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    iss_nxt      = iss_r;
    s1_v_nxt     = (state_r == S_SCAN) && (iss_r != n_r);
    s1_idx_nxt   = scan_v;
    first_nxt    = first_r;
    pick_nxt     = pick_r;
    picks_nxt    = picks_r;
    conn_ok_nxt  = conn_ok_r;
    best_nxt     = best_r;
    bidx_nxt     = bidx_r;
    found_nxt    = found_r;
    ffree_nxt    = ffree_r;
    ffree_ok_nxt = ffree_ok_r;
    in_tree_nxt  = in_tree_r;
    conn_nxt     = conn_r;
    ov_nxt       = ov_r;
    clr_nxt      = clr_r;
    oval_nxt     = oval_r;
    overt_nxt    = overt_r;
    opar_nxt     = opar_r;
    owgt_nxt     = owgt_r;
    oreach_nxt   = oreach_r;
    olast_nxt    = olast_r;

    // fold the returning vertex into the running minimum
    if (s1_v_r && !it_cur) begin
      if (!ffree_ok_r) begin
        ffree_nxt    = s1_idx_r;
        ffree_ok_nxt = 1'b1;
      end
      if (knew < best_r) begin
        best_nxt  = knew;
        bidx_nxt  = s1_idx_r;
        found_nxt = 1'b1;
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (&clr_r) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (in_fire && in_edge.last_edge) begin
          n_nxt        = n_cfg;
          iss_nxt      = '0;
          first_nxt    = 1'b1;
          pick_nxt     = '0;
          picks_nxt    = '0;
          conn_ok_nxt  = 1'b1;
          in_tree_nxt  = '0;
          conn_nxt     = '0;
          best_nxt     = KEY_INF;
          found_nxt    = 1'b0;
          ffree_ok_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (iss_r != n_r) begin
          iss_nxt = iss_r + CW'(1);
        end else if (!s1_v_r) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        in_tree_nxt[pick_sel] = 1'b1;
        conn_nxt[pick_sel]    = conn_now;
        conn_ok_nxt           = conn_now;
        picks_nxt             = picks_inc;
        if (picks_inc == n_r) begin
          ov_nxt  = CW'(1);
          clr_nxt = '0;
          state_nxt = (n_r == CW'(1)) ? S_CLEAR : S_ORD;
        end else begin
          pick_nxt     = pick_sel;
          iss_nxt      = '0;
          first_nxt    = 1'b0;
          best_nxt     = KEY_INF;
          found_nxt    = 1'b0;
          ffree_ok_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_ORD: begin
        state_nxt = S_OLD;
      end
      S_OLD: begin
        oval_nxt   = 1'b1;
        overt_nxt  = vert_t'(ov_r);
        opar_nxt   = vert_t'(par_q_r);
        owgt_nxt   = key_q_r[KW-1] ? '0 : wgt_t'(key_q_r[WEIGHT_BITS-1:0]);
        oreach_nxt = conn_r[ov_r[VW-1:0]];
        olast_nxt  = (ov_r == n_r - CW'(1));
        state_nxt  = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_fire) begin
          oval_nxt = 1'b0;
          if (olast_r) begin
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end else begin
            ov_nxt    = ov_r + CW'(1);
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        clr_nxt   = '0;
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      vcount_r   <= VCOUNT_RESET;
      n_r        <= '0;
      iss_r      <= '0;
      s1_v_r     <= 1'b0;
      first_r    <= 1'b0;
      pick_r     <= '0;
      picks_r    <= '0;
      conn_ok_r  <= 1'b0;
      found_r    <= 1'b0;
      ffree_ok_r <= 1'b0;
      in_tree_r  <= '0;
      conn_r     <= '0;
      ov_r       <= '0;
      clr_r      <= '0;
      oval_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        vcount_r <= cfg_wr.vertex_count;
      end
      n_r        <= n_nxt;
      iss_r      <= iss_nxt;
      s1_v_r     <= s1_v_nxt;
      first_r    <= first_nxt;
      pick_r     <= pick_nxt;
      picks_r    <= picks_nxt;
      conn_ok_r  <= conn_ok_nxt;
      found_r    <= found_nxt;
      ffree_ok_r <= ffree_ok_nxt;
      in_tree_r  <= in_tree_nxt;
      conn_r     <= conn_nxt;
      ov_r       <= ov_nxt;
      clr_r      <= clr_nxt;
      oval_r     <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= s1_idx_nxt;
    best_r   <= best_nxt;
    bidx_r   <= bidx_nxt;
    ffree_r  <= ffree_nxt;
    overt_r  <= overt_nxt;
    opar_r   <= opar_nxt;
    owgt_r   <= owgt_nxt;
    oreach_r <= oreach_nxt;
    olast_r  <= olast_nxt;
  end

  `PMST_ASSERT_IMP(a_load_excl_out, clk, rst_n, in_edge.ready, !out_tree.valid)
  `PMST_ASSERT_IMP(a_pick_has_vertex, clk, rst_n, state_r == S_PICK, found_r || ffree_ok_r)
  `PMST_ASSERT_IMP(a_pick_is_new, clk, rst_n, state_r == S_PICK, !in_tree_r[pick_sel])
  `PMST_ASSERT_IMP(a_scan_bounded, clk, rst_n, state_r == S_SCAN, picks_r < n_r)
  `PMST_ASSERT_NEXT(a_last_clears, clk, rst_n, out_fire && out_tree.last_result, state_r == S_CLEAR)

endmodule

`default_nettype wire
